// ----- src/uart_register_fifo_block_defines.svh -----
// ----------------------------------------------------------------------------
// uart_register_fifo_block_defines
// Assertion macros used by the checker of the UART register block.
// ----------------------------------------------------------------------------
`ifndef UART_REGISTER_FIFO_BLOCK_DEFINES_SVH
`define UART_REGISTER_FIFO_BLOCK_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define URFB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define URFB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/urfb_pkg.sv -----
// ----------------------------------------------------------------------------
// urfb_pkg
// Types, codes and sizes shared by the UART register block modules.
// ----------------------------------------------------------------------------
package urfb_pkg;

	// FIFO sizes and derived widths
	localparam int RX_DEPTH = 8;
	localparam int TX_DEPTH = 8;
	localparam int RX_PTR_W = $clog2(RX_DEPTH);
	localparam int TX_PTR_W = $clog2(TX_DEPTH);
	localparam int RX_CNT_W = $clog2(RX_DEPTH + 1);
	localparam int TX_CNT_W = $clog2(TX_DEPTH + 1);
	// width for comparing the receive level with a 3-bit watermark
	localparam int WM_CMP_W = RX_CNT_W + 3;

	// read values
	localparam logic [31:0] EMPTY_MARK = 32'h8000_0000;
	localparam logic [31:0] FULL_BIT   = 32'h8000_0000;

	// bit positions in ip and ie
	localparam int IP_TXWM = 0;
	localparam int IP_RXWM = 1;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_RXBYTE = 2'd2,
		OP_DRAIN = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		SEL_TXDATA = 3'd0,
		SEL_RXDATA = 3'd1,
		SEL_TXCTRL = 3'd2,
		SEL_RXCTRL = 3'd3,
		SEL_IE     = 3'd4,
		SEL_IP     = 3'd5,
		SEL_DIV    = 3'd6,
		SEL_NONE   = 3'd7
	} reg_sel_t;

	// controller to datapath commands
	typedef struct packed {
		logic     exec;
		logic     rd_en;
		reg_sel_t rd_sel;
		logic     rx_push;
		logic     rx_pop;
		logic     rx_drop;
		logic     tx_push;
		logic     tx_ovf;
		logic     tx_pop;
		logic     drain;
		logic     wr_txctrl;
		logic     wr_rxctrl;
		logic     wr_ie;
		logic     wr_div;
	} urfb_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic rx_empty;
		logic rx_full;
		logic tx_empty;
		logic tx_full;
	} urfb_stat_t;

endpackage

// ----- src/urfb_ctrl.sv -----
// ----------------------------------------------------------------------------
// urfb_ctrl
// Request decoder and response sequencer: turns each request into datapath
// commands using the FIFO status, and marks the cycle its result is shown.
// ----------------------------------------------------------------------------
module urfb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [1:0]          opcode,
	input  logic [2:0]          reg_sel,
	input  logic                sink_ready,
	input  urfb_pkg::urfb_stat_t stat,
	output urfb_pkg::urfb_cmd_t  cmd,
	output logic                busy,
	output logic                done
);
	import urfb_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_RESP
	} state_t;

	state_t   state_q;
	opcode_t  op;
	reg_sel_t sel;

	assign op  = opcode_t'(opcode);
	assign sel = reg_sel_t'(reg_sel);

	// every request completes in one step, so requests are never held off
	assign busy = 1'b0;
	assign done = (state_q == ST_RESP);

	// decode the request against the FIFO status
	always_comb begin
		cmd = '0;
		cmd.exec   = start;
		cmd.rd_sel = sel;
		if (start) begin
			unique case (op)
				OP_READ: begin
					cmd.rd_en  = 1'b1;
					cmd.rx_pop = (sel == SEL_RXDATA) && !stat.rx_empty;
				end
				OP_WRITE: begin
					cmd.tx_push   = (sel == SEL_TXDATA) && !stat.tx_full;
					cmd.tx_ovf    = (sel == SEL_TXDATA) && stat.tx_full;
					cmd.wr_txctrl = (sel == SEL_TXCTRL);
					cmd.wr_rxctrl = (sel == SEL_RXCTRL);
					cmd.wr_ie     = (sel == SEL_IE);
					cmd.wr_div    = (sel == SEL_DIV);
				end
				OP_RXBYTE: begin
					cmd.rx_push = !stat.rx_full;
					cmd.rx_drop = stat.rx_full;
				end
				OP_DRAIN: begin
					cmd.drain  = 1'b1;
					cmd.tx_pop = sink_ready && !stat.tx_empty;
				end
				default: begin
				end
			endcase
		end
	end

	// show the result in the cycle after each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= start ? ST_RESP : ST_IDLE;
		end
	end

endmodule

// ----- src/urfb_dp.sv -----
// ----------------------------------------------------------------------------
// urfb_dp
// Datapath: receive and transmit FIFO rings, control registers, read mux and
// the registered result.
// ----------------------------------------------------------------------------
module urfb_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  urfb_pkg::urfb_cmd_t  cmd,
	input  logic [31:0]         write_data,
	input  logic [7:0]          rx_byte,
	output urfb_pkg::urfb_stat_t stat,
	output logic [31:0]         read_data,
	output logic                irq,
	output logic                tx_valid,
	output logic [7:0]          tx_byte,
	output logic                rx_dropped,
	output logic                tx_overflow
);
	import urfb_pkg::*;

	logic [7:0]          rx_mem [RX_DEPTH];
	logic [7:0]          tx_mem [TX_DEPTH];
	logic [RX_PTR_W-1:0] rx_head_q, rx_tail_q;
	logic [TX_PTR_W-1:0] tx_head_q, tx_tail_q;
	logic [RX_CNT_W-1:0] rx_lvl_q, rx_lvl_d;
	logic [TX_CNT_W-1:0] tx_lvl_q, tx_lvl_d;
	logic                tx_full_q, tx_full_d;
	logic [31:0]         txctrl_q, rxctrl_q, ie_q, div_q, ie_d;
	logic [31:0]         ip_val;
	logic                irq_d;

	// FIFO status for the controller
	assign stat.rx_empty = (rx_lvl_q == '0);
	assign stat.rx_full  = (rx_lvl_q == RX_CNT_W'(RX_DEPTH));
	assign stat.tx_empty = (tx_lvl_q == '0);
	assign stat.tx_full  = (tx_lvl_q == TX_CNT_W'(TX_DEPTH));

	// next levels, full flag and interrupt level
	always_comb begin
		rx_lvl_d = rx_lvl_q;
		if (cmd.rx_push) begin
			rx_lvl_d = rx_lvl_q + 1'b1;
		end else if (cmd.rx_pop) begin
			rx_lvl_d = rx_lvl_q - 1'b1;
		end
		tx_lvl_d = tx_lvl_q;
		if (cmd.tx_push) begin
			tx_lvl_d = tx_lvl_q + 1'b1;
		end else if (cmd.tx_pop) begin
			tx_lvl_d = tx_lvl_q - 1'b1;
		end
		tx_full_d = tx_full_q;
		if (cmd.tx_push || cmd.tx_ovf) begin
			tx_full_d = tx_full_q | (tx_lvl_d == TX_CNT_W'(TX_DEPTH));
		end else if (cmd.drain && (tx_lvl_d != TX_CNT_W'(TX_DEPTH))) begin
			tx_full_d = 1'b0;
		end
		ie_d  = cmd.wr_ie ? write_data : ie_q;
		irq_d = ie_d[IP_TXWM] | (ie_d[IP_RXWM] & (rx_lvl_d != '0));
	end

	// pending bits from the watermark fields
	always_comb begin
		ip_val = '0;
		ip_val[IP_TXWM] = |txctrl_q[18:16];
		ip_val[IP_RXWM] = (WM_CMP_W'(rx_lvl_q) > WM_CMP_W'(rxctrl_q[18:16]));
	end

	// control state: levels, pointers, flag and registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_head_q <= '0;
			rx_tail_q <= '0;
			rx_lvl_q  <= '0;
			tx_head_q <= '0;
			tx_tail_q <= '0;
			tx_lvl_q  <= '0;
			tx_full_q <= 1'b0;
			txctrl_q  <= '0;
			rxctrl_q  <= '0;
			ie_q      <= '0;
			div_q     <= '0;
		end else if (cmd.exec) begin
			rx_lvl_q  <= rx_lvl_d;
			tx_lvl_q  <= tx_lvl_d;
			tx_full_q <= tx_full_d;
			ie_q      <= ie_d;
			if (cmd.rx_push) begin
				rx_tail_q <= (rx_tail_q == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : rx_tail_q + 1'b1;
			end
			if (cmd.rx_pop) begin
				rx_head_q <= (rx_head_q == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : rx_head_q + 1'b1;
			end
			if (cmd.tx_push) begin
				tx_tail_q <= (tx_tail_q == TX_PTR_W'(TX_DEPTH - 1)) ? '0 : tx_tail_q + 1'b1;
			end
			if (cmd.tx_pop) begin
				tx_head_q <= (tx_head_q == TX_PTR_W'(TX_DEPTH - 1)) ? '0 : tx_head_q + 1'b1;
			end
			if (cmd.wr_txctrl) begin
				txctrl_q <= write_data;
			end
			if (cmd.wr_rxctrl) begin
				rxctrl_q <= write_data;
			end
			if (cmd.wr_div) begin
				div_q <= write_data;
			end
		end
	end

	// FIFO storage writes
	always_ff @(posedge clk) begin
		if (cmd.rx_push) begin
			rx_mem[rx_tail_q] <= rx_byte;
		end
		if (cmd.tx_push) begin
			tx_mem[tx_tail_q] <= write_data[7:0];
		end
	end

	// register the result of the request, reading the FIFO heads
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (cmd.rd_en) begin
				unique case (cmd.rd_sel)
					SEL_TXDATA: read_data <= tx_full_q ? FULL_BIT : '0;
					SEL_RXDATA: read_data <= stat.rx_empty ? EMPTY_MARK
						: {24'h00_0000, rx_mem[rx_head_q]};
					SEL_TXCTRL: read_data <= txctrl_q;
					SEL_RXCTRL: read_data <= rxctrl_q;
					SEL_IE:     read_data <= ie_q;
					SEL_IP:     read_data <= ip_val;
					SEL_DIV:    read_data <= div_q;
					SEL_NONE:   read_data <= '0;
				endcase
			end else begin
				read_data <= '0;
			end
			irq         <= irq_d;
			tx_valid    <= cmd.tx_pop;
			tx_byte     <= cmd.tx_pop ? tx_mem[tx_head_q] : 8'h00;
			rx_dropped  <= cmd.rx_drop;
			tx_overflow <= cmd.tx_ovf;
		end
	end

endmodule

// ----- src/uart_register_fifo_block.sv -----
// ----------------------------------------------------------------------------
// uart_register_fifo_block
// Result: the result of a request shows on the result ports, marked by done,
//   in the cycle after start is taken.
// Throughput: one request per cycle; busy stays low, every step is one update
//   of the FIFO pointers and registers.
// Reset: arst_n clears levels, pointers, full flag and registers at once.
// ----------------------------------------------------------------------------
module uart_register_fifo_block (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [2:0]  reg_sel,
	input  logic [31:0] write_data,
	input  logic [7:0]  rx_byte,
	input  logic        sink_ready,
	output logic        done,
	output logic [31:0] read_data,
	output logic        irq,
	output logic        tx_valid,
	output logic [7:0]  tx_byte,
	output logic        rx_dropped,
	output logic        tx_overflow
);
	import urfb_pkg::*;

	urfb_cmd_t  cmd;
	urfb_stat_t stat;

	// decode requests and sequence responses
	urfb_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.opcode     (opcode),
		.reg_sel    (reg_sel),
		.sink_ready (sink_ready),
		.stat       (stat),
		.cmd        (cmd),
		.busy       (busy),
		.done       (done)
	);

	// FIFOs, registers and result
	urfb_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.write_data  (write_data),
		.rx_byte     (rx_byte),
		.stat        (stat),
		.read_data   (read_data),
		.irq         (irq),
		.tx_valid    (tx_valid),
		.tx_byte     (tx_byte),
		.rx_dropped  (rx_dropped),
		.tx_overflow (tx_overflow)
	);

endmodule

// ----- src/urfb_checker.sv -----
// ----------------------------------------------------------------------------
// urfb_checker
// Port-level checks of the UART register block, bound to the top level.
// ----------------------------------------------------------------------------
`include "uart_register_fifo_block_defines.svh"

module urfb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [1:0]  opcode,
	input logic        done,
	input logic [31:0] read_data,
	input logic        tx_valid,
	input logic        rx_dropped,
	input logic        tx_overflow
);
	import urfb_pkg::*;

	// each accepted request yields exactly one result in the next cycle
	`URFB_ASSERT_NEXT(a_req_done, start && !busy, done, "accepted request gave no result")
	`URFB_ASSERT_NEXT(a_no_extra, !(start && !busy), !done, "result without a request")

	// one event per request: send, drop and overflow never coincide
	`URFB_ASSERT_NOW(a_one_event, done, $onehot0({tx_valid, rx_dropped, tx_overflow}),
		"more than one event flag in one result")

	// read data is non-zero only for bus reads
	`URFB_ASSERT_NOW(a_rd_only, done && (read_data != '0), $past(opcode) == OP_READ,
		"read data on a request that was not a read")

endmodule

bind uart_register_fifo_block urfb_checker u_chk (.*);

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UART register block. Bus reads and writes,
// received bytes and drain ticks are queued as requests. A clocked driver issues
// them with random idle bursts. A local predictor of both FIFOs and the
// registers computes each response when its request is taken. A clocked
// monitor compares every done strobe, field by field, with the oldest
// predicted response.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import urfb_pkg::*;

	typedef struct {
		opcode_t     op;
		reg_sel_t    sel;
		logic [31:0] wdata;
		logic [7:0]  rbyte;
		logic        ready;
		int unsigned idle_before;
		bit          wait_empty;
	} uart_req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        irq;
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic        rx_dropped;
		logic        tx_overflow;
	} uart_resp_t;

	localparam int TOTAL_REQS = 1675;
	localparam int CALM_TAIL  = 200;

	// clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #5 clk = ~clk;

	// block ports
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  opcode = '0;
	logic [2:0]  reg_sel = '0;
	logic [31:0] write_data = '0;
	logic [7:0]  rx_byte = '0;
	logic        sink_ready = 1'b0;
	logic        done;
	logic [31:0] read_data;
	logic        irq;
	logic        tx_valid;
	logic [7:0]  tx_byte;
	logic        rx_dropped;
	logic        tx_overflow;

	uart_register_fifo_block u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.opcode     (opcode),
		.reg_sel    (reg_sel),
		.write_data (write_data),
		.rx_byte    (rx_byte),
		.sink_ready (sink_ready),
		.done       (done),
		.read_data  (read_data),
		.irq        (irq),
		.tx_valid   (tx_valid),
		.tx_byte    (tx_byte),
		.rx_dropped (rx_dropped),
		.tx_overflow(tx_overflow)
	);

	// request stream, predicted responses, error count
	uart_req_t  uart_requests[$];
	uart_resp_t expected_responses[$];
	int         fail_count = 0;

	// predictor state
	logic [7:0]  rx_fifo[$];
	logic [7:0]  tx_fifo[$];
	logic        tx_full;
	logic [31:0] ie_reg;
	logic [31:0] txctrl_reg;
	logic [31:0] rxctrl_reg;
	logic [31:0] div_reg;

	// compute the response of one request and advance the predicted state
	function automatic uart_resp_t predict_uart_response(uart_req_t rq);
		uart_resp_t rs;
		rs = '0;
		case (rq.op)
			OP_READ: begin
				case (rq.sel)
					SEL_TXDATA: rs.read_data = tx_full ? FULL_BIT : 32'd0;
					SEL_RXDATA: begin
						if (rx_fifo.size() == 0)
							rs.read_data = EMPTY_MARK;
						else
							rs.read_data = {24'd0, rx_fifo.pop_front()};
					end
					SEL_TXCTRL: rs.read_data = txctrl_reg;
					SEL_RXCTRL: rs.read_data = rxctrl_reg;
					SEL_IE:     rs.read_data = ie_reg;
					SEL_IP: begin
						rs.read_data[IP_TXWM] = (txctrl_reg[18:16] != 3'd0);
						rs.read_data[IP_RXWM] = (rx_fifo.size() > int'(rxctrl_reg[18:16]));
					end
					SEL_DIV:    rs.read_data = div_reg;
					default:    rs.read_data = 32'd0;
				endcase
			end
			OP_WRITE: begin
				case (rq.sel)
					SEL_TXDATA: begin
						if (tx_fifo.size() >= TX_DEPTH)
							rs.tx_overflow = 1'b1;
						else
							tx_fifo.push_back(rq.wdata[7:0]);
						if (tx_fifo.size() >= TX_DEPTH)
							tx_full = 1'b1;
					end
					SEL_TXCTRL: txctrl_reg = rq.wdata;
					SEL_RXCTRL: rxctrl_reg = rq.wdata;
					SEL_IE:     ie_reg = rq.wdata;
					SEL_DIV:    div_reg = rq.wdata;
					default: ;
				endcase
			end
			OP_RXBYTE: begin
				if (rx_fifo.size() >= RX_DEPTH)
					rs.rx_dropped = 1'b1;
				else
					rx_fifo.push_back(rq.rbyte);
			end
			default: begin
				if (rq.ready && tx_fifo.size() != 0) begin
					rs.tx_valid = 1'b1;
					rs.tx_byte = tx_fifo.pop_front();
				end
				// any drain tick releases the full flag once there is room
				if (tx_fifo.size() < TX_DEPTH)
					tx_full = 1'b0;
			end
		endcase
		rs.irq = ie_reg[IP_TXWM] | (ie_reg[IP_RXWM] & (rx_fifo.size() != 0));
		return rs;
	endfunction

	// driver: record taken requests, then issue the next one after its idle gap
	uart_req_t   cur_req;
	int unsigned idle_cnt = 0;

	always @(posedge clk or negedge arst_n) begin
		logic      next_start;
		uart_req_t nxt;
		if (!arst_n) begin
			start <= 1'b0;
			opcode <= '0;
			reg_sel <= '0;
			write_data <= '0;
			rx_byte <= '0;
			sink_ready <= 1'b0;
			idle_cnt = 0;
		end else begin
			next_start = start;
			if (start && !busy) begin
				expected_responses.push_back(predict_uart_response(cur_req));
				next_start = 1'b0;
			end
			if (!next_start && uart_requests.size() != 0) begin
				nxt = uart_requests[0];
				if (nxt.wait_empty && expected_responses.size() != 0) begin
					// hold until every response is back
				end else if (idle_cnt < nxt.idle_before) begin
					idle_cnt++;
				end else begin
					void'(uart_requests.pop_front());
					cur_req = nxt;
					idle_cnt = 0;
					next_start = 1'b1;
					opcode <= nxt.op;
					reg_sel <= nxt.sel;
					write_data <= nxt.wdata;
					rx_byte <= nxt.rbyte;
					sink_ready <= nxt.ready;
				end
			end
			start <= next_start;
		end
	end

	// monitor: compare each strobe with the oldest predicted response
	always @(posedge clk) begin
		uart_resp_t exp_rs;
		if (arst_n && done) begin
			if (expected_responses.size() == 0) begin
				$error("response with no request outstanding");
				fail_count++;
			end else begin
				exp_rs = expected_responses.pop_front();
				if (read_data !== exp_rs.read_data) begin
					$error("read_data: expected %h, got %h", exp_rs.read_data, read_data);
					fail_count++;
				end
				if (irq !== exp_rs.irq) begin
					$error("irq: expected %b, got %b", exp_rs.irq, irq);
					fail_count++;
				end
				if (tx_valid !== exp_rs.tx_valid) begin
					$error("tx_valid: expected %b, got %b", exp_rs.tx_valid, tx_valid);
					fail_count++;
				end
				if (tx_byte !== exp_rs.tx_byte) begin
					$error("tx_byte: expected %h, got %h", exp_rs.tx_byte, tx_byte);
					fail_count++;
				end
				if (rx_dropped !== exp_rs.rx_dropped) begin
					$error("rx_dropped: expected %b, got %b", exp_rs.rx_dropped, rx_dropped);
					fail_count++;
				end
				if (tx_overflow !== exp_rs.tx_overflow) begin
					$error("tx_overflow: expected %b, got %b",
						exp_rs.tx_overflow, tx_overflow);
					fail_count++;
				end
			end
		end
	end

	// request with every field random but the idle gap and the wait flag
	function automatic uart_req_t rand_request();
		uart_req_t rq;
		rq.op = opcode_t'($urandom_range(0, 3));
		rq.sel = reg_sel_t'($urandom_range(0, 7));
		rq.wdata = $urandom;
		rq.rbyte = 8'($urandom);
		rq.ready = 1'($urandom);
		rq.idle_before = 0;
		rq.wait_empty = 1'b0;
		return rq;
	endfunction

	// idle density of the current stretch: 0 none, 1 sparse, 2 heavy
	int idle_mode = 0;

	task automatic add_request(uart_req_t rq);
		int n;
		n = uart_requests.size();
		if (n % 100 == 0)
			idle_mode = $urandom_range(0, 2);
		rq.idle_before = 0;
		if (n < TOTAL_REQS - CALM_TAIL) begin
			if ((idle_mode == 1 && $urandom_range(0, 9) == 0) ||
				(idle_mode == 2 && $urandom_range(0, 2) == 0))
				rq.idle_before = $urandom_range(1, 10);
		end
		if (n == 400 || n == 1000 || n == 1300)
			rq.wait_empty = 1'b1;
		uart_requests.push_back(rq);
	endtask

	task automatic add_op(opcode_t op, reg_sel_t sel);
		uart_req_t rq;
		rq = rand_request();
		rq.op = op;
		rq.sel = sel;
		add_request(rq);
	endtask

	// register value: zero, all ones, random, or small with a watermark field
	function automatic logic [31:0] reg_value();
		case ($urandom_range(0, 3))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom;
			default: return 32'($urandom_range(0, 3)) | (32'($urandom_range(0, 7)) << 16);
		endcase
	endfunction

	task automatic build_requests();
		uart_req_t rq;
		int        len;
		// directed: reads after reset, ignored writes, empty drain
		for (int s = 0; s < 8; s++)
			add_op(OP_READ, reg_sel_t'(s));
		rq = rand_request();
		rq.op = OP_WRITE;
		rq.wdata = 32'hFFFF_FFFF;
		rq.sel = SEL_NONE;
		add_request(rq);
		rq.sel = SEL_RXDATA;
		add_request(rq);
		rq.sel = SEL_IP;
		add_request(rq);
		rq = rand_request();
		rq.op = OP_DRAIN;
		rq.ready = 1'b1;
		add_request(rq);
		// directed: fill the transmit FIFO past full, then release the flag
		for (int k = 0; k < TX_DEPTH + 1; k++) begin
			rq = rand_request();
			rq.op = OP_WRITE;
			rq.sel = SEL_TXDATA;
			if (k == 0)
				rq.wdata = 32'd0;
			else if (k == 1)
				rq.wdata = 32'hFFFF_FFFF;
			add_request(rq);
		end
		add_op(OP_READ, SEL_TXDATA);
		rq = rand_request();
		rq.op = OP_DRAIN;
		rq.ready = 1'b0;
		add_request(rq);
		rq.ready = 1'b1;
		add_request(rq);
		add_op(OP_READ, SEL_TXDATA);

		// random: mostly FIFO bursts and register traffic, some noise
		while (uart_requests.size() < TOTAL_REQS) begin
			len = $urandom_range(1, 11);
			case ($urandom_range(0, 9))
				0, 1: begin
					for (int k = 0; k < len; k++) begin
						if ($urandom_range(0, 5) == 0)
							add_op(OP_READ, SEL_TXDATA);
						else
							add_op(OP_WRITE, SEL_TXDATA);
					end
				end
				2: begin
					for (int k = 0; k < len; k++) begin
						rq = rand_request();
						rq.op = OP_DRAIN;
						rq.ready = ($urandom_range(0, 3) != 0);
						add_request(rq);
					end
				end
				3, 4: begin
					for (int k = 0; k < len; k++)
						add_op(OP_RXBYTE, reg_sel_t'($urandom_range(0, 7)));
				end
				5: begin
					for (int k = 0; k < len; k++) begin
						if ($urandom_range(0, 4) == 0)
							add_op(OP_READ, SEL_IP);
						else
							add_op(OP_READ, SEL_RXDATA);
					end
				end
				6: begin
					rq = rand_request();
					rq.op = OP_WRITE;
					rq.wdata = reg_value();
					add_request(rq);
				end
				7: add_op(OP_READ, reg_sel_t'($urandom_range(0, 7)));
				default: begin
					for (int k = 0; k < len; k++)
						add_request(rand_request());
				end
			endcase
		end
	endtask

	initial begin
		tx_full = 1'b0;
		ie_reg = '0;
		txctrl_reg = '0;
		rxctrl_reg = '0;
		div_reg = '0;
		build_requests();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		// let every request go out, then collect the last responses
		while (uart_requests.size() != 0 || start)
			@(negedge clk);
		for (int i = 0; i < 50 && expected_responses.size() != 0; i++)
			@(negedge clk);
		repeat (5) @(negedge clk);
		if (expected_responses.size() != 0) begin
			$error("%0d responses never arrived", expected_responses.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// stop a hung run
	initial begin
		#3_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
